[src/sinusoid_kalman_tracker_top_assert.svh]
// Assertion macros for the tracker's checker file.
// Depends on nothing; included by the checker module.
`ifndef SINUSOID_KALMAN_TRACKER_TOP_ASSERT_SVH
`define SINUSOID_KALMAN_TRACKER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SKT_ASSERT_IMPL(label, clk_s, rst_s, lhs, rhs, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (lhs) |-> (rhs)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define SKT_ASSERT_NEXT(label, clk_s, rst_s, lhs, rhs, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (lhs) |=> (rhs)) \
    else $error(msg);
`endif

[src/skt_pkg.sv]
// Shared types and constants of the Kalman tracker.
// Depends on nothing; imported by the datapath, controller and top level.
package skt_pkg;
  localparam int DefDataWidth = 32;
  localparam int DefFracBits = 28;
  localparam int CfgIdxWidth = 3;
  localparam int CfgDataWidth = 32;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_COS = 3'd0, REG_SIN = 3'd1, REG_Q00 = 3'd2, REG_Q01 = 3'd3,
    REG_Q10 = 3'd4, REG_Q11 = 3'd5, REG_R = 3'd6
  } reg_idx_t;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NOP, OP_MUL, OP_ADD, OP_SUB, OP_DIV, OP_MOV
  } op_t;

  // Register file slots of the datapath.
  localparam int SlotWidth = 5;
  typedef enum logic [SlotWidth-1:0] {
    S_C, S_S, S_Q00, S_Q01, S_Q10, S_Q11, S_R, S_Z,
    S_X0, S_X1, S_P00, S_P01, S_P10, S_P11,
    S_T0, S_T1, S_T2, S_T3, S_A00, S_A01, S_A10, S_A11,
    S_D, S_K0, S_K1, S_Y, S_N0
  } slot_t;

  typedef struct packed {
    logic  start;
    op_t   op;
    slot_t src_a;
    slot_t src_b;
    slot_t dst;
    logic  load;
    logic  commit;
  } skt_cmd_t;

  typedef struct packed {
    logic busy;
  } skt_status_t;
endpackage

[src/skt_datapath.sv]
// Datapath of the tracker: slot register file, one shared multiplier with a
// rounding stage, a saturating adder and a restoring divider. Uses skt_pkg.
module skt_datapath #(
  parameter int DATA_WIDTH = skt_pkg::DefDataWidth,
  parameter int FRAC_BITS = skt_pkg::DefFracBits
) (
  input  logic                          clk,
  input  logic                          rst,
  input  skt_pkg::skt_cmd_t             cmd,
  output skt_pkg::skt_status_t          status,
  input  logic                          cfg_we,
  input  logic [skt_pkg::CfgIdxWidth-1:0]  cfg_idx,
  input  logic [skt_pkg::CfgDataWidth-1:0] cfg_data,
  input  logic signed [31:0]            sample,
  output logic signed [31:0]            est_out,
  output logic signed [31:0]            quad_out,
  output logic                          sat_out
);
  import skt_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int NSLOT = 27;
  localparam int DW = W + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W+1:0] ONE_WIDE = (W + 1 > FRAC_BITS + 1) ?
    ((W+2)'(1) <<< FRAC_BITS) : (W+2)'(VMAX);
  // Reset values of the cosine and measurement noise registers, clamped
  // to the word when they do not fit.
  localparam logic signed [W-1:0] COS_RST = (W >= 30) ? W'(268435456) : VMAX;
  localparam logic signed [W-1:0] R_RST = (W >= 26) ? W'(26843546) : VMAX;

  logic signed [W-1:0] rf [NSLOT];
  logic sat;

  // Clamp a wider signed value to the data width.
  function automatic logic signed [W-1:0] clamp_w(input logic signed [W+1:0] v,
                                                  output logic hit);
    hit = 1'b0;
    if (v > (W+2)'(VMAX)) begin
      hit = 1'b1;
      clamp_w = VMAX;
    end else if (v < (W+2)'(VMIN)) begin
      hit = 1'b1;
      clamp_w = VMIN;
    end else begin
      clamp_w = v[W-1:0];
    end
  endfunction

  function automatic logic signed [W+1:0] sx(input logic signed [W-1:0] v);
    sx = (W+2)'(v);
  endfunction

  logic signed [W-1:0] opa, opb;
  assign opa = rf[cmd.src_a];
  assign opb = rf[cmd.src_b];

  // Multiplier: magnitudes, one registered product, then rounding.
  logic [W-1:0] mag_a, mag_b;
  logic         mul_neg, mul_neg_q;
  logic [PW-1:0] prod_q;
  logic [1:0]    mul_cnt;
  slot_t         mul_dst;
  assign mag_a = opa[W-1] ? W'(-opa) : opa;
  assign mag_b = opb[W-1] ? W'(-opb) : opb;
  assign mul_neg = opa[W-1] ^ opb[W-1];

  logic [PW:0]   rnd;
  logic [PW:0]   shifted;
  logic [W:0]    lim_m;
  logic signed [W-1:0] mul_res;
  logic          mul_hit;
  assign rnd = {1'b0, prod_q} + ((PW+1)'(1) << (FRAC_BITS - 1));
  assign shifted = rnd >> FRAC_BITS;
  assign lim_m = mul_neg_q ? ((W+1)'(VMAX) + 1'b1) : (W+1)'(VMAX);
  always_comb begin
    mul_hit = shifted > (PW+1)'(lim_m);
    if (mul_hit) mul_res = mul_neg_q ? VMIN : VMAX;
    else mul_res = mul_neg_q ? W'(-shifted[W-1:0]) : shifted[W-1:0];
  end

  // Saturating add and subtract.
  logic signed [W+1:0] sum_w;
  logic signed [W-1:0] sum_res;
  logic sum_hit;
  always_comb begin
    sum_w = (cmd.op == OP_SUB) ? sx(opa) - sx(opb) : sx(opa) + sx(opb);
    sum_res = clamp_w(sum_w, sum_hit);
  end

  // Restoring divider: (|num| << FRAC_BITS) / den, one bit a cycle.
  logic [DW-1:0] dnum;
  logic [W:0]    drem;
  logic [DW-1:0] dquo;
  logic [W-1:0]  dden;
  logic [CW-1:0] dcnt;
  logic          dneg, dact, dsat;
  slot_t         ddst;
  logic [W:0]    rem_sh;
  logic          ge;
  assign rem_sh = {drem[W-1:0], dnum[DW-1]};
  assign ge = rem_sh >= {1'b0, dden};

  logic [DW:0]   qr;
  logic [W:0]    lim_d;
  logic signed [W-1:0] div_res;
  logic          div_hit;
  always_comb begin
    qr = {1'b0, dquo} + ((drem >= ({1'b0, dden} - drem)) ? (DW+1)'(1) : (DW+1)'(0));
    lim_d = dneg ? ((W+1)'(VMAX) + 1'b1) : (W+1)'(VMAX);
    div_hit = qr > (DW+1)'(lim_d);
    if (div_hit) div_res = dneg ? VMIN : VMAX;
    else div_res = dneg ? W'(-qr[W-1:0]) : qr[W-1:0];
  end

  assign status.busy = (mul_cnt != 2'd0) || dact;

  logic signed [W+1:0] cfg_wide;
  logic                cfg_hit;
  logic signed [W-1:0] cfg_val;
  logic signed [W-1:0] z_val;
  logic                z_hit;
  always_comb begin
    case (cfg_idx)
      REG_COS, REG_SIN: cfg_wide = (W+2)'($signed(cfg_data[29:0]));
      REG_R:            cfg_wide = (W+2)'($signed({1'b0, cfg_data[30:0]}));
      default:          cfg_wide = (W+2)'($signed(cfg_data));
    endcase
    cfg_val = clamp_w(cfg_wide, cfg_hit);
    z_val = clamp_w((W+2)'(sample), z_hit);
  end

  logic signed [W-1:0] one_v;
  logic                one_hit;
  assign one_v = clamp_w(ONE_WIDE, one_hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      rf[S_C]   <= COS_RST;
      rf[S_S]   <= '0;
      rf[S_Q00] <= '0;
      rf[S_Q01] <= '0;
      rf[S_Q10] <= '0;
      rf[S_Q11] <= '0;
      rf[S_R]   <= R_RST;
      rf[S_X0]  <= '0;
      rf[S_X1]  <= one_v;
      rf[S_P00] <= one_v;
      rf[S_P01] <= '0;
      rf[S_P10] <= '0;
      rf[S_P11] <= one_v;
      mul_cnt <= 2'd0;
      dact <= 1'b0;
      sat <= 1'b0;
      sat_out <= 1'b0;
      est_out <= '0;
      quad_out <= '0;
    end else begin
      if (cfg_we && cfg_idx <= REG_R) rf[SlotWidth'(cfg_idx)] <= cfg_val;
      if (cmd.load) begin
        rf[S_Z] <= z_val;
        sat <= z_hit;
      end
      if (mul_cnt == 2'd1) begin
        rf[mul_dst] <= mul_res;
        if (mul_hit) sat <= 1'b1;
      end
      if (mul_cnt != 2'd0) mul_cnt <= mul_cnt - 2'd1;
      if (dact) begin
        if (dcnt == '0) begin
          dact <= 1'b0;
          rf[ddst] <= div_res;
          if (div_hit) sat <= 1'b1;
        end else begin
          dcnt <= dcnt - 1'b1;
          dnum <= dnum << 1;
          dquo <= {dquo[DW-2:0], ge};
          drem <= ge ? rem_sh - {1'b0, dden} : rem_sh;
        end
      end
      if (cmd.start) begin
        case (cmd.op)
          OP_MUL: begin
            prod_q <= PW'(mag_a) * PW'(mag_b);
            mul_neg_q <= mul_neg;
            mul_dst <= cmd.dst;
            mul_cnt <= 2'd2;
          end
          OP_ADD, OP_SUB: begin
            rf[cmd.dst] <= sum_res;
            if (sum_hit) sat <= 1'b1;
          end
          OP_MOV: rf[cmd.dst] <= opa;
          OP_DIV: begin
            if (opb <= 0) begin
              rf[cmd.dst] <= opa[W-1] ? VMIN : VMAX;
              sat <= 1'b1;
            end else begin
              dnum <= {mag_a, {FRAC_BITS{1'b0}}};
              dden <= opb;
              drem <= '0;
              dquo <= '0;
              dneg <= opa[W-1];
              ddst <= cmd.dst;
              dcnt <= CW'(DW);
              dact <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd.commit) begin
        est_out <= 32'(rf[S_X0]);
        quad_out <= 32'(rf[S_X1]);
        sat_out <= sat;
      end
    end
  end

  logic unused;
  assign unused = one_hit ^ cfg_hit;
endmodule

[src/skt_ctrl.sv]
// Controller of the tracker: a sequencer that walks the fixed program of
// predict and update operations. Uses skt_pkg.
module skt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  skt_pkg::skt_status_t status,
  output skt_pkg::skt_cmd_t    cmd
);
  import skt_pkg::*;

  localparam int NPROG = 50;
  localparam int PCW = 6;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_DONE} state_t;
  state_t state;
  logic [PCW-1:0] pc;

  function automatic skt_cmd_t prog(input logic [PCW-1:0] i);
    skt_cmd_t c;
    c = '0;
    c.start = 1'b1;
    case (i)
      6'd0:  begin c.op = OP_MUL; c.src_a = S_C;   c.src_b = S_X0;  c.dst = S_T0; end
      6'd1:  begin c.op = OP_MUL; c.src_a = S_S;   c.src_b = S_X1;  c.dst = S_T1; end
      6'd2:  begin c.op = OP_MUL; c.src_a = S_S;   c.src_b = S_X0;  c.dst = S_T2; end
      6'd3:  begin c.op = OP_MUL; c.src_a = S_C;   c.src_b = S_X1;  c.dst = S_T3; end
      6'd4:  begin c.op = OP_SUB; c.src_a = S_T0;  c.src_b = S_T1;  c.dst = S_X0; end
      6'd5:  begin c.op = OP_ADD; c.src_a = S_T2;  c.src_b = S_T3;  c.dst = S_X1; end
      6'd6:  begin c.op = OP_MUL; c.src_a = S_C;   c.src_b = S_P00; c.dst = S_T0; end
      6'd7:  begin c.op = OP_MUL; c.src_a = S_S;   c.src_b = S_P10; c.dst = S_T1; end
      6'd8:  begin c.op = OP_MUL; c.src_a = S_C;   c.src_b = S_P01; c.dst = S_T2; end
      6'd9:  begin c.op = OP_MUL; c.src_a = S_S;   c.src_b = S_P11; c.dst = S_T3; end
      6'd10: begin c.op = OP_SUB; c.src_a = S_T0;  c.src_b = S_T1;  c.dst = S_A00; end
      6'd11: begin c.op = OP_SUB; c.src_a = S_T2;  c.src_b = S_T3;  c.dst = S_A01; end
      6'd12: begin c.op = OP_MUL; c.src_a = S_S;   c.src_b = S_P00; c.dst = S_T0; end
      6'd13: begin c.op = OP_MUL; c.src_a = S_C;   c.src_b = S_P10; c.dst = S_T1; end
      6'd14: begin c.op = OP_MUL; c.src_a = S_S;   c.src_b = S_P01; c.dst = S_T2; end
      6'd15: begin c.op = OP_MUL; c.src_a = S_C;   c.src_b = S_P11; c.dst = S_T3; end
      6'd16: begin c.op = OP_ADD; c.src_a = S_T0;  c.src_b = S_T1;  c.dst = S_A10; end
      6'd17: begin c.op = OP_ADD; c.src_a = S_T2;  c.src_b = S_T3;  c.dst = S_A11; end
      6'd18: begin c.op = OP_MUL; c.src_a = S_A00; c.src_b = S_C;   c.dst = S_T0; end
      6'd19: begin c.op = OP_MUL; c.src_a = S_A01; c.src_b = S_S;   c.dst = S_T1; end
      6'd20: begin c.op = OP_MUL; c.src_a = S_A00; c.src_b = S_S;   c.dst = S_T2; end
      6'd21: begin c.op = OP_MUL; c.src_a = S_A01; c.src_b = S_C;   c.dst = S_T3; end
      6'd22: begin c.op = OP_SUB; c.src_a = S_T0;  c.src_b = S_T1;  c.dst = S_P00; end
      6'd23: begin c.op = OP_ADD; c.src_a = S_T2;  c.src_b = S_T3;  c.dst = S_P01; end
      6'd24: begin c.op = OP_MUL; c.src_a = S_A10; c.src_b = S_C;   c.dst = S_T0; end
      6'd25: begin c.op = OP_MUL; c.src_a = S_A11; c.src_b = S_S;   c.dst = S_T1; end
      6'd26: begin c.op = OP_MUL; c.src_a = S_A10; c.src_b = S_S;   c.dst = S_T2; end
      6'd27: begin c.op = OP_MUL; c.src_a = S_A11; c.src_b = S_C;   c.dst = S_T3; end
      6'd28: begin c.op = OP_SUB; c.src_a = S_T0;  c.src_b = S_T1;  c.dst = S_P10; end
      6'd29: begin c.op = OP_ADD; c.src_a = S_T2;  c.src_b = S_T3;  c.dst = S_P11; end
      6'd30: begin c.op = OP_ADD; c.src_a = S_P00; c.src_b = S_Q00; c.dst = S_P00; end
      6'd31: begin c.op = OP_ADD; c.src_a = S_P01; c.src_b = S_Q01; c.dst = S_P01; end
      6'd32: begin c.op = OP_ADD; c.src_a = S_P10; c.src_b = S_Q10; c.dst = S_P10; end
      6'd33: begin c.op = OP_ADD; c.src_a = S_P11; c.src_b = S_Q11; c.dst = S_P11; end
      6'd34: begin c.op = OP_ADD; c.src_a = S_P00; c.src_b = S_R;   c.dst = S_D; end
      6'd35: begin c.op = OP_DIV; c.src_a = S_P00; c.src_b = S_D;   c.dst = S_K0; end
      6'd36: begin c.op = OP_DIV; c.src_a = S_P10; c.src_b = S_D;   c.dst = S_K1; end
      6'd37: begin c.op = OP_SUB; c.src_a = S_Z;   c.src_b = S_X0;  c.dst = S_Y; end
      6'd38: begin c.op = OP_MUL; c.src_a = S_K0;  c.src_b = S_Y;   c.dst = S_T0; end
      6'd39: begin c.op = OP_MUL; c.src_a = S_K1;  c.src_b = S_Y;   c.dst = S_T1; end
      6'd40: begin c.op = OP_MUL; c.src_a = S_K0;  c.src_b = S_P00; c.dst = S_A00; end
      6'd41: begin c.op = OP_MUL; c.src_a = S_K0;  c.src_b = S_P01; c.dst = S_A01; end
      6'd42: begin c.op = OP_MUL; c.src_a = S_K1;  c.src_b = S_P00; c.dst = S_A10; end
      6'd43: begin c.op = OP_MUL; c.src_a = S_K1;  c.src_b = S_P01; c.dst = S_A11; end
      6'd44: begin c.op = OP_ADD; c.src_a = S_X0;  c.src_b = S_T0;  c.dst = S_X0; end
      6'd45: begin c.op = OP_ADD; c.src_a = S_X1;  c.src_b = S_T1;  c.dst = S_X1; end
      6'd46: begin c.op = OP_SUB; c.src_a = S_P00; c.src_b = S_A00; c.dst = S_P00; end
      6'd47: begin c.op = OP_SUB; c.src_a = S_P01; c.src_b = S_A01; c.dst = S_P01; end
      6'd48: begin c.op = OP_SUB; c.src_a = S_P10; c.src_b = S_A10; c.dst = S_P10; end
      6'd49: begin c.op = OP_SUB; c.src_a = S_P11; c.src_b = S_A11; c.dst = S_P11; end
      default: c.start = 1'b0;
    endcase
    return c;
  endfunction

  localparam logic [PCW-1:0] LAST = PCW'(NPROG - 1);

  skt_cmd_t step_cmd;
  assign step_cmd = prog(pc);

  // The result registers are loaded once, after the last operation has
  // landed, so the saturation flag covers the whole program.
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: cmd.load = in_valid && !out_valid;
      ST_RUN:  cmd = step_cmd;
      ST_DONE: cmd.commit = !status.busy;
      default: ;
    endcase
  end

  assign in_stall = (state != ST_IDLE) || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (in_valid && !out_valid) begin
          state <= ST_WAIT;
          pc <= '0;
        end
        ST_RUN: begin
          state <= ST_WAIT;
          if (pc == LAST) state <= ST_DONE;
        end
        ST_WAIT: if (!status.busy) begin
          state <= ST_RUN;
          pc <= pc;
        end
        ST_DONE: if (!status.busy) begin
          state <= ST_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
      if (state == ST_RUN) pc <= pc + 1'b1;
    end
  end
endmodule

[src/sinusoid_kalman_tracker_top.sv]
// Two-state oscillator Kalman tracker in signed fixed point.
// Input channel: sample with sample_valid / sample_stall; a transaction is
// taken at a clock edge where sample_valid is high and sample_stall is low.
// Output channel: estimate, quadrature, saturated with result_valid /
// result_stall; one result transaction follows every input transaction.
// Each sample runs a fixed program of fifty operations, one at a time: a
// product on the shared multiplier is registered and then rounded into its
// slot, an add or subtract is written directly, and a gain runs on the
// bit-serial divider (a gain whose divisor is not positive is written
// saturated without the divider). One sample is in flight at a time: the
// next can be taken no sooner than the cycle after the result has been
// taken.
// Configuration writes (cfg_we, cfg_index, cfg_data) load the rotation,
// process noise and measurement noise registers and belong in idle time.
// Reset (rst, synchronous, active high) restores the registers, the state
// to zero in phase and one in quadrature, and the covariance to identity.
// While result_valid and result_stall are both high the result holds and no new sample is taken.
module sinusoid_kalman_tracker_top #(
  parameter int DATA_WIDTH = skt_pkg::DefDataWidth,
  parameter int FRAC_BITS = skt_pkg::DefFracBits
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [skt_pkg::CfgIdxWidth-1:0]  cfg_index,
  input  logic [skt_pkg::CfgDataWidth-1:0] cfg_data,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  logic signed [31:0]               sample,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic signed [31:0]               estimate,
  output logic signed [31:0]               quadrature,
  output logic                             saturated
);
  import skt_pkg::*;

  skt_cmd_t    cmd;
  skt_status_t status;

  // The sequencer issues one operation at a time and waits on busy.
  skt_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(sample_valid), .in_stall(sample_stall),
    .out_valid(result_valid), .out_stall(result_stall),
    .status(status), .cmd(cmd)
  );

  skt_datapath #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .sample(sample), .est_out(estimate), .quad_out(quadrature),
    .sat_out(saturated)
  );
endmodule

[src/skt_checker.sv]
// Port-level checker for the tracker, bound to the top level.
// Depends on the assertion macro header.
`include "sinusoid_kalman_tracker_top_assert.svh"
module skt_port_checker (
  input logic clk,
  input logic rst,
  input logic sample_valid,
  input logic sample_stall,
  input logic result_valid,
  input logic result_stall
);
  `SKT_ASSERT_NEXT(a_take_no_result, clk, rst, sample_valid && !sample_stall, !result_valid, "early result")
  `SKT_ASSERT_IMPL(a_stall_while_result, clk, rst, result_valid, sample_stall, "input not stalled")
  `SKT_ASSERT_NEXT(a_result_holds, clk, rst, result_valid && result_stall, result_valid, "result dropped")
endmodule

bind sinusoid_kalman_tracker_top skt_port_checker u_skt_port_checker (
  .clk(clk), .rst(rst), .sample_valid(sample_valid), .sample_stall(sample_stall),
  .result_valid(result_valid), .result_stall(result_stall)
);
